@@ rtl/dte_pkg.sv @@
// shared constants, types and tables for the epoch to calendar date converter
// no dependencies; imported by every module of the block
`default_nettype none
package dte_pkg;

    // pipeline depth from transaction accept to result register
    localparam int unsigned DTE_LAT = 7;

    // seconds per day is 128 * 675: shift by 7, then divide by 675
    localparam int unsigned DTE_DAY_SHIFT = 7;
    localparam logic [9:0]  DTE_DAY_DIV   = 10'd675;
    // floor(2^35 / 675), quotient estimate is exact or one low
    localparam logic [25:0] DTE_DAY_RCP   = 26'd50903316;

    // ceil(2^23 / 60) for seconds of day to minutes of day
    localparam logic [17:0] DTE_MIN_RCP   = 18'd139811;
    // ceil(2^17 / 60) for minutes of day to hours
    localparam logic [11:0] DTE_HOUR_RCP  = 12'd2185;
    localparam logic [5:0]  DTE_SIXTY     = 6'd60;

    // day count is rebased to 1968-01-01, start of a four year cycle
    localparam logic [15:0] DTE_REBASE    = 16'd731;
    // rebased day of 2100-03-01, from here on a phantom 29 february is inserted
    localparam logic [15:0] DTE_SKIP_DAY  = 16'd48272;
    // ceil(2^26 / 1461) for the four year cycle
    localparam logic [15:0] DTE_CYC_RCP   = 16'd45934;
    localparam logic [10:0] DTE_CYC_DAYS  = 11'd1461;
    localparam logic [7:0]  DTE_BASE_YEAR = 8'd68;
    // the only century year in range that is not a leap year
    localparam logic [7:0]  DTE_CENTURY   = 8'd200;
    localparam logic [8:0]  DTE_MAR_FIRST = 9'd59;

    // time of day result
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // calendar date result
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [8:0] yday;
    } t_date;

    // first day of year of each month
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dte_split.sv @@
// splits epoch seconds into day number and seconds of day, three stages
// depends on dte_pkg
`default_nettype none
module dte_split (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_epoch,
    output logic      [16:0] o_secs,
    output logic      [15:0] o_rday
);
    import dte_pkg::*;

    logic [24:0] r_x1;
    logic [6:0]  r_lo1;
    logic [15:0] r_q1;
    logic [10:0] r_rem2;
    logic [15:0] r_q2;
    logic [6:0]  r_lo2;
    logic [16:0] r_secs3;
    logic [15:0] r_rday3;

    logic [50:0] n_prod;
    logic [25:0] n_qmul;
    logic [25:0] n_rem;
    logic [15:0] n_q;
    logic [10:0] n_r;
    logic [15:0] n_base;

    // stage 1: reciprocal multiply of the upper bits
    assign n_prod = 51'(i_epoch[31:DTE_DAY_SHIFT]) * 51'(DTE_DAY_RCP);

    // stage 2: remainder of the estimate
    assign n_qmul = 26'(r_q1) * 26'(DTE_DAY_DIV);
    assign n_rem  = 26'(r_x1) - n_qmul;

    // stage 3: one step correction, rebase day count
    always_comb begin
        n_q = r_q2;
        n_r = r_rem2;
        if (r_rem2 >= 11'(DTE_DAY_DIV)) begin
            n_q = r_q2 + 16'd1;
            n_r = r_rem2 - 11'(DTE_DAY_DIV);
        end
        n_base = n_q + DTE_REBASE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= i_epoch[31:DTE_DAY_SHIFT];
            r_lo1   <= i_epoch[DTE_DAY_SHIFT-1:0];
            r_q1    <= n_prod[50:35];
            r_rem2  <= n_rem[10:0];
            r_q2    <= r_q1;
            r_lo2   <= r_lo1;
            r_secs3 <= {n_r[9:0], r_lo2};
            r_rday3 <= n_base + ((n_base >= DTE_SKIP_DAY) ? 16'd1 : 16'd0);
        end
    end

    assign o_secs = r_secs3;
    assign o_rday = r_rday3;

endmodule
`default_nettype wire

@@ rtl/dte_tod.sv @@
// seconds of day to hour, minute and second, four stages
// depends on dte_pkg
`default_nettype none
module dte_tod (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic   [16:0] i_secs,
    output dte_pkg::t_tod      o_tod
);
    import dte_pkg::*;

    logic [34:0] r_prod1;
    logic [16:0] r_secs1;
    logic [10:0] r_mt2;
    logic [5:0]  r_sec2;
    logic [22:0] r_prod3;
    logic [10:0] r_mt3;
    logic [5:0]  r_sec3;
    t_tod        r_tod4;

    logic [16:0] n_sec;
    logic [10:0] n_min;
    logic [4:0]  n_hour;

    // minute of day from seconds, remainder is the second
    assign n_sec  = r_secs1 - 17'(r_prod1[33:23]) * 17'(DTE_SIXTY);
    // hour from minute of day, remainder is the minute
    assign n_hour = r_prod3[21:17];
    assign n_min  = r_mt3 - 11'(n_hour) * 11'(DTE_SIXTY);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1       <= 35'(i_secs) * 35'(DTE_MIN_RCP);
            r_secs1       <= i_secs;
            r_mt2         <= r_prod1[33:23];
            r_sec2        <= n_sec[5:0];
            r_prod3       <= 23'(r_mt2) * 23'(DTE_HOUR_RCP);
            r_mt3         <= r_mt2;
            r_sec3        <= r_sec2;
            r_tod4.hour   <= n_hour;
            r_tod4.minute <= n_min[5:0];
            r_tod4.second <= r_sec3;
        end
    end

    assign o_tod = r_tod4;

endmodule
`default_nettype wire

@@ rtl/dte_date.sv @@
// rebased day number to year, month, day of month and day of year, four stages
// depends on dte_pkg
`default_nettype none
module dte_date (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic   [15:0] i_rday,
    output dte_pkg::t_date     o_date
);
    import dte_pkg::*;

    logic [31:0] r_prod1;
    logic [15:0] r_rday1;
    logic [5:0]  r_cyc2;
    logic [10:0] r_rem2;
    logic [7:0]  r_year3;
    logic [8:0]  r_yday3;
    logic        r_leap3;
    t_date       r_date4;

    logic [15:0] n_rem;
    logic [1:0]  n_yr;
    logic [10:0] n_yday;
    logic [3:0]  n_mon;
    logic [8:0]  n_mday;
    logic        n_skip;

    // day within the four year cycle
    assign n_rem = r_rday1 - 16'(r_prod1[31:26]) * 16'(DTE_CYC_DAYS);

    // year within the cycle, first year is the leap one
    always_comb begin
        if (r_rem2 < 11'd366) begin
            n_yr   = 2'd0;
            n_yday = r_rem2;
        end else if (r_rem2 < 11'd731) begin
            n_yr   = 2'd1;
            n_yday = r_rem2 - 11'd366;
        end else if (r_rem2 < 11'd1096) begin
            n_yr   = 2'd2;
            n_yday = r_rem2 - 11'd731;
        end else begin
            n_yr   = 2'd3;
            n_yday = r_rem2 - 11'd1096;
        end
    end

    // month search over the start table, then day of month
    always_comb begin
        n_mon = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_yday3 >= month_start(r_leap3, 4'(m))) begin
                n_mon = 4'(m);
            end
        end
        n_mday = r_yday3 - month_start(r_leap3, n_mon) + 9'd1;
        // 2100 carries a phantom 29 february, drop it from the day of year
        n_skip = (r_year3 == DTE_CENTURY) && (r_yday3 >= DTE_MAR_FIRST);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1       <= 32'(i_rday) * 32'(DTE_CYC_RCP);
            r_rday1       <= i_rday;
            r_cyc2        <= r_prod1[31:26];
            r_rem2        <= n_rem[10:0];
            r_year3       <= DTE_BASE_YEAR + {r_cyc2, 2'b00} + 8'(n_yr);
            r_yday3       <= n_yday[8:0];
            r_leap3       <= (n_yr == 2'd0);
            r_date4.year  <= r_year3;
            r_date4.month <= n_mon;
            r_date4.mday  <= n_mday[4:0];
            r_date4.yday  <= r_yday3 - (n_skip ? 9'd1 : 9'd0);
        end
    end

    assign o_date = r_date4;

endmodule
`default_nettype wire

@@ rtl/epoch_to_calendar_date.sv @@
// throughput: one transaction per cycle unless a held result stalls, set by the seven stage pipeline
// a stalled result holds the whole pipeline; it moves again when the stall drops
// reset clears the valid bits only, the data stages hold no control state
// depends on dte_pkg, dte_split, dte_tod, dte_date
`default_nettype none
module epoch_to_calendar_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [5:0]  o_second,
    output logic      [5:0]  o_minute,
    output logic      [4:0]  o_hour,
    output logic      [4:0]  o_day_of_month,
    output logic      [3:0]  o_month_index,
    output logic      [7:0]  o_year_since_1900,
    output logic      [8:0]  o_day_of_year
);
    import dte_pkg::*;

    logic [DTE_LAT-1:0] r_vld;
    logic               en;
    logic [16:0]        secs;
    logic [15:0]        rday;
    t_tod               tod;
    t_date              date;

    // whole pipeline advances unless a finished result is held
    assign en         = !(r_vld[DTE_LAT-1] && i_out_stall);
    assign o_in_stall = !en;

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DTE_LAT-2:0], i_in_valid};
        end
    end

    dte_split u_split (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_epoch (i_epoch_seconds),
        .o_secs  (secs),
        .o_rday  (rday)
    );

    dte_tod u_tod (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_secs (secs),
        .o_tod  (tod)
    );

    dte_date u_date (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rday (rday),
        .o_date (date)
    );

    // result transaction
    assign o_out_valid       = r_vld[DTE_LAT-1];
    assign o_second          = tod.second;
    assign o_minute          = tod.minute;
    assign o_hour            = tod.hour;
    assign o_day_of_month    = date.mday;
    assign o_month_index     = date.month;
    assign o_year_since_1900 = date.year;
    assign o_day_of_year     = date.yday;

endmodule
`default_nettype wire
